[sv/ple_pkg.sv]
// shared constants and codes for the positional list engine
package ple_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int POS_W = 5;
  localparam int VALUE_W = 32;
  localparam int LEN_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_TRAVERSE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[sv/ple_ram.sv]
// generic simple dual-port ram with registered read
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/positional_list_engine_unit.sv]
// positional list engine: ordered list with insert, delete and traverse at an index
//
// Command channel (cmd_valid, cmd_stall, command, position, value) takes one
// transaction at a time; cmd_stall is high while a command is being worked on.
// Result channel (res_valid, res_stall, item_value, has_value, status, length,
// last) comes from an output register and holds while res_stall is high.
// Entries live in a single simple dual-port ram; inserts and deletes move the
// tail one entry per cycle through its read port and write port.
// Steps from accept to the result being loaded, with n the current length:
//   insert   : shift entries n-1 down to position up by one, fill, emit; error emit
//   delete   : shift entries after position down by one, emit; error emit
//   traverse : read first entry, then one entry per cycle unless stalled; empty list emit
// The next command is taken in the cycle after the last result is loaded, so
// a status result may still wait in the output register meanwhile.
// A stalled receiver freezes the sequencer at the output register.
// Reset empties the list at once (length zero); no clearing pass is needed.
module positional_list_engine_unit #(
  parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic [1:0]                      command,
  input  logic [ple_pkg::POS_W-1:0]       position,
  input  logic signed [ple_pkg::VALUE_W-1:0] value,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic signed [ple_pkg::VALUE_W-1:0] item_value,
  output logic                            has_value,
  output logic [1:0]                      status,
  output logic [ple_pkg::LEN_W-1:0]       length,
  output logic                            last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + ple_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_FILL,
    S_SHIFT_DN,
    S_EMIT,
    S_TRAV_RD,
    S_TRAV_OUT
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 count;
  logic [AW-1:0]                 ptr;
  logic [AW-1:0]                 pos_r;
  logic [ple_pkg::VALUE_W-1:0]   val_r;
  logic                          wpend;
  logic [AW-1:0]                 wad;
  ple_pkg::status_t              res_status;

  logic                          out_free;
  logic                          res_load;
  logic                          rd_issue;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  logic [ple_pkg::VALUE_W-1:0]   wdata;
  logic [ple_pkg::VALUE_W-1:0]   rdata;
  logic [XW-1:0]                 pos_x;
  logic [XW-1:0]                 cnt_x;
  logic                          dn_more;
  logic                          trav_last;

  assign pos_x     = XW'(position);
  assign cnt_x     = XW'(count);
  assign dn_more   = (CW'(ptr) + CW'(1)) < count;
  assign trav_last = (CW'(ptr) + CW'(1)) == count;
  assign out_free  = !res_valid || !res_stall;
  assign res_load  = out_free && (state == S_EMIT || state == S_TRAV_OUT);
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    rd_issue = 1'b0;
    raddr    = ptr;
    case (state)
      S_SHIFT_UP: begin
        rd_issue = (ptr != pos_r);
        raddr    = ptr - AW'(1);
      end
      S_SHIFT_DN: begin
        rd_issue = dn_more;
        raddr    = ptr + AW'(1);
      end
      S_TRAV_RD: begin
        rd_issue = 1'b1;
      end
      S_TRAV_OUT: begin
        rd_issue = 1'b1;
        if (out_free) begin
          raddr = ptr + AW'(1);
        end
      end
      default: begin
        rd_issue = 1'b0;
      end
    endcase
  end

  assign we    = wpend || (state == S_FILL);
  assign waddr = (state == S_FILL) ? pos_r : wad;
  assign wdata = (state == S_FILL) ? val_r : rdata;

  ple_ram #(
    .WIDTH (ple_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wpend     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      wpend <= 1'b0;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            pos_r <= AW'(position);
            val_r <= value;
            case (ple_pkg::cmd_t'(command))
              ple_pkg::CMD_INSERT: begin
                if (pos_x > cnt_x) begin
                  res_status <= ple_pkg::ST_RANGE;
                  state      <= S_EMIT;
                end else if (count >= CW'(DEPTH)) begin
                  res_status <= ple_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else begin
                  ptr   <= AW'(count);
                  state <= S_SHIFT_UP;
                end
              end
              ple_pkg::CMD_DELETE: begin
                if (pos_x >= cnt_x) begin
                  res_status <= ple_pkg::ST_RANGE;
                  state      <= S_EMIT;
                end else begin
                  ptr   <= AW'(position);
                  state <= S_SHIFT_DN;
                end
              end
              default: begin
                res_status <= ple_pkg::ST_OK;
                if (count == '0) begin
                  state <= S_EMIT;
                end else begin
                  ptr   <= '0;
                  state <= S_TRAV_RD;
                end
              end
            endcase
          end
        end
        S_SHIFT_UP: begin
          if (ptr == pos_r) begin
            state <= S_FILL;
          end else begin
            wpend <= 1'b1;
            wad   <= ptr;
            ptr   <= ptr - AW'(1);
          end
        end
        S_FILL: begin
          count      <= count + CW'(1);
          res_status <= ple_pkg::ST_OK;
          state      <= S_EMIT;
        end
        S_SHIFT_DN: begin
          if (dn_more) begin
            wpend <= 1'b1;
            wad   <= ptr;
            ptr   <= ptr + AW'(1);
          end else begin
            count      <= count - CW'(1);
            res_status <= ple_pkg::ST_OK;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            item_value <= '0;
            has_value  <= 1'b0;
            status     <= res_status;
            length     <= ple_pkg::LEN_W'(count);
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_TRAV_RD: begin
          state <= S_TRAV_OUT;
        end
        S_TRAV_OUT: begin
          if (out_free) begin
            item_value <= rdata;
            has_value  <= 1'b1;
            status     <= ple_pkg::ST_OK;
            length     <= ple_pkg::LEN_W'(count);
            last       <= trav_last;
            ptr        <= ptr + AW'(1);
            if (trav_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("list length beyond depth");

  a_fill_excl: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> !wpend)
    else $error("shift write collides with fill write");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (rd_issue && wpend) |-> (raddr != wad))
    else $error("shift reads the entry being written");

  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && has_value) |-> (status == ple_pkg::ST_OK))
    else $error("traverse result with error status");

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_UP || state == S_SHIFT_DN) |=> $stable(pos_r))
    else $error("position changed during a shift");

endmodule

[verif/testbench.sv]
// testbench for the positional list engine: directed table, random commands, queue-based predictor
module testbench;

  localparam int LIST_DEPTH = ple_pkg::DEPTH_DEFAULT;
  localparam logic [1:0] CMD_TRAVERSE_ALIAS = 2'd3;
  localparam int RANDOM_COMMANDS = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_AT = 60;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam logic signed [ple_pkg::VALUE_W-1:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [ple_pkg::VALUE_W-1:0] WORD_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [ple_pkg::VALUE_W-1:0] item_value;
    logic has_value;
    ple_pkg::status_t status;
    logic [ple_pkg::LEN_W-1:0] length;
    logic last;
  } list_result_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [ple_pkg::POS_W-1:0] pos;
    logic signed [ple_pkg::VALUE_W-1:0] val;
    logic typed;
    ple_pkg::status_t want_status;
    logic [ple_pkg::LEN_W-1:0] want_length;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  logic [1:0] command;
  logic [ple_pkg::POS_W-1:0] position;
  logic signed [ple_pkg::VALUE_W-1:0] value;
  logic res_valid;
  logic res_stall;
  logic signed [ple_pkg::VALUE_W-1:0] item_value;
  logic has_value;
  logic [1:0] status;
  logic [ple_pkg::LEN_W-1:0] length;
  logic last;

  logic signed [ple_pkg::VALUE_W-1:0] list_entries[$];
  list_result_t pending_results[$];
  int failures = 0;
  int results_checked = 0;
  int commands_sent = 0;
  int full_rejects = 0;
  int range_rejects = 0;

  positional_list_engine_unit #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .command(command),
    .position(position),
    .value(value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .item_value(item_value),
    .has_value(has_value),
    .status(status),
    .length(length),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #(8 * 500000);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic void apply_list_command(logic [1:0] cmd, logic [ple_pkg::POS_W-1:0] pos,
                                             logic signed [ple_pkg::VALUE_W-1:0] val);
    list_result_t r;
    int n;
    n = list_entries.size();
    r.item_value = '0;
    r.has_value = 1'b0;
    r.status = ple_pkg::ST_OK;
    r.length = '0;
    r.last = 1'b1;
    case (cmd)
      ple_pkg::CMD_INSERT: begin
        if (pos > n) r.status = ple_pkg::ST_RANGE;
        else if (n >= LIST_DEPTH) r.status = ple_pkg::ST_FULL;
        else list_entries.insert(pos, val);
        r.length = ple_pkg::LEN_W'(list_entries.size());
        pending_results.push_back(r);
      end
      ple_pkg::CMD_DELETE: begin
        if (pos >= n) r.status = ple_pkg::ST_RANGE;
        else list_entries.delete(pos);
        r.length = ple_pkg::LEN_W'(list_entries.size());
        pending_results.push_back(r);
      end
      default: begin
        r.length = ple_pkg::LEN_W'(n);
        if (n == 0) begin
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.item_value = list_entries[i];
            r.has_value = 1'b1;
            r.last = (i == n - 1);
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      failures++;
    end
  endfunction

  function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // result side: compare every transaction with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && res_valid && !res_stall) begin
      results_checked++;
      if (status == ple_pkg::ST_FULL) full_rejects++;
      if (status == ple_pkg::ST_RANGE) range_rejects++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual value %h status %0d",
                 $time, item_value, status);
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("item_value", want.item_value, item_value);
        check_field("has_value", 32'(want.has_value), 32'(has_value));
        check_field("status", 32'(want.status), 32'(status));
        check_field("length", 32'(want.length), 32'(length));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // receiver: random waits, recurring quiet stretches and one long hold
  initial begin
    int rx_count;
    int wait_cycles;
    rx_count = 0;
    res_stall = 1'b0;
    forever begin
      if (rx_count == LONG_HOLD_AT) begin
        res_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = (rx_count % 90 >= 30 && rx_count % 90 < 60) ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        res_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (rst || res_valid !== 1'b1);
      rx_count++;
    end
  end

  task automatic send_command(input logic [1:0] cmd, input logic [ple_pkg::POS_W-1:0] pos,
                              input logic signed [ple_pkg::VALUE_W-1:0] val);
    int gap;
    gap = (commands_sent % 100 >= 40 && commands_sent % 100 < 70) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command <= cmd;
    position <= pos;
    value <= val;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    apply_list_command(cmd, pos, val);
    commands_sent++;
  endtask

  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    stim_row_t directed_rows[0:20];
    list_result_t typed_result;
    int len;
    int pick;
    bit growing;
    bit main_op;

    rst = 1'b1;
    cmd_valid = 1'b0;
    command = ple_pkg::CMD_INSERT;
    position = '0;
    value = '0;
    growing = 1'b1;

    directed_rows = '{
      '{ple_pkg::CMD_TRAVERSE, 5'd0,  32'sd0,        1'b1, ple_pkg::ST_OK,    5'd0},
      '{ple_pkg::CMD_DELETE,   5'd0,  32'sd0,        1'b1, ple_pkg::ST_RANGE, 5'd0},
      '{ple_pkg::CMD_INSERT,   5'd1,  32'sd5,        1'b1, ple_pkg::ST_RANGE, 5'd0},
      '{ple_pkg::CMD_INSERT,   5'd0,  WORD_MAX,      1'b1, ple_pkg::ST_OK,    5'd1},
      '{ple_pkg::CMD_INSERT,   5'd1,  WORD_MIN,      1'b1, ple_pkg::ST_OK,    5'd2},
      '{ple_pkg::CMD_INSERT,   5'd0,  -32'sd1,       1'b1, ple_pkg::ST_OK,    5'd3},
      '{ple_pkg::CMD_INSERT,   5'd3,  32'sd0,        1'b1, ple_pkg::ST_OK,    5'd4},
      '{ple_pkg::CMD_INSERT,   5'd31, 32'sh5a5a5a5a, 1'b1, ple_pkg::ST_RANGE, 5'd4},
      '{ple_pkg::CMD_INSERT,   5'd2,  32'sh00001234, 1'b1, ple_pkg::ST_OK,    5'd5},
      '{ple_pkg::CMD_TRAVERSE, 5'd0,  32'sd0,        1'b0, ple_pkg::ST_OK,    5'd0},
      '{CMD_TRAVERSE_ALIAS,    5'd31, -32'sd1,       1'b0, ple_pkg::ST_OK,    5'd0},
      '{ple_pkg::CMD_DELETE,   5'd5,  32'sd0,        1'b1, ple_pkg::ST_RANGE, 5'd5},
      '{ple_pkg::CMD_DELETE,   5'd31, WORD_MAX,      1'b1, ple_pkg::ST_RANGE, 5'd5},
      '{ple_pkg::CMD_DELETE,   5'd4,  32'sd0,        1'b1, ple_pkg::ST_OK,    5'd4},
      '{ple_pkg::CMD_DELETE,   5'd0,  32'sd0,        1'b1, ple_pkg::ST_OK,    5'd3},
      '{ple_pkg::CMD_DELETE,   5'd1,  32'sd0,        1'b1, ple_pkg::ST_OK,    5'd2},
      '{ple_pkg::CMD_TRAVERSE, 5'd0,  32'sd0,        1'b0, ple_pkg::ST_OK,    5'd0},
      '{ple_pkg::CMD_DELETE,   5'd0,  32'sd0,        1'b1, ple_pkg::ST_OK,    5'd1},
      '{ple_pkg::CMD_DELETE,   5'd0,  32'sd0,        1'b1, ple_pkg::ST_OK,    5'd0},
      '{ple_pkg::CMD_TRAVERSE, 5'd0,  32'sd0,        1'b1, ple_pkg::ST_OK,    5'd0},
      '{ple_pkg::CMD_INSERT,   5'd0,  32'sh55555555, 1'b1, ple_pkg::ST_OK,    5'd1}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val);
      if (directed_rows[i].typed) begin
        typed_result.item_value = '0;
        typed_result.has_value = 1'b0;
        typed_result.status = directed_rows[i].want_status;
        typed_result.length = directed_rows[i].want_length;
        typed_result.last = 1'b1;
        void'(pending_results.pop_back());
        pending_results.push_back(typed_result);
      end
    end
    send_command(ple_pkg::CMD_TRAVERSE, '0, '0);
    wait_for_results();

    // fill to capacity, then try the full list
    while (list_entries.size() < LIST_DEPTH) begin
      send_command(ple_pkg::CMD_INSERT,
                   ple_pkg::POS_W'($urandom_range(0, list_entries.size())), pick_value());
    end
    send_command(ple_pkg::CMD_INSERT, '0, pick_value());
    send_command(ple_pkg::CMD_INSERT, ple_pkg::POS_W'(LIST_DEPTH), pick_value());
    send_command(ple_pkg::CMD_INSERT, ple_pkg::POS_W'(LIST_DEPTH + 1), pick_value());
    send_command(ple_pkg::CMD_TRAVERSE, ple_pkg::POS_W'($urandom_range(0, 31)), pick_value());

    for (int k = 0; k < RANDOM_COMMANDS; k++) begin
      if (k == RANDOM_COMMANDS / 2) wait_for_results();
      len = list_entries.size();
      if (growing && len == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (!growing && len == 0) growing = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        main_op = (pick < 60);
        if (main_op == growing)
          send_command(ple_pkg::CMD_INSERT, ple_pkg::POS_W'($urandom_range(0, len)),
                       pick_value());
        else
          send_command(ple_pkg::CMD_DELETE,
                       ple_pkg::POS_W'((len == 0) ? 0 : $urandom_range(0, len - 1)),
                       pick_value());
      end else if (pick < 88) begin
        send_command(($urandom_range(0, 3) == 0) ? CMD_TRAVERSE_ALIAS : ple_pkg::CMD_TRAVERSE,
                     ple_pkg::POS_W'($urandom_range(0, 31)), pick_value());
      end else begin
        send_command(2'($urandom_range(0, 3)), ple_pkg::POS_W'($urandom_range(0, 31)),
                     pick_value());
      end
    end
    wait_for_results();

    $display("ran %0d commands and checked %0d results", commands_sent, results_checked);
    $display("rejects seen: %0d list full, %0d bad position", full_rejects, range_rejects);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
